// ----- design/ptl_pkg.sv -----
// shared types, constants and tables for the pad to lab transform
package ptl_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int MaxStages = 24;

  // cordic datapath width: 16-bit input with 16 fraction bits plus growth
  localparam int CW = 36;
  // angle accumulator in 2^-16 degree
  localparam int AW = 26;

  localparam logic [16:0] Cos20Q16 = 17'd61583;
  localparam logic [15:0] Sin20Q16 = 16'd22415;

  // request state handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  enabled;
    logic [2:0]            sector;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [AW-1:0]  ang;
    logic                  origin;
    logic signed [15:0]    lab_x;
    logic signed [15:0]    lab_y;
    logic signed [15:0]    lab_z;
    logic signed [16:0]    ref_az;
  } ptl_cell_t;

  // arctangent table in 2^-16 degree
  function automatic logic [AW-1:0] atan_q16(input logic [4:0] i);
    logic [AW-1:0] r;
    begin
      case (i)
        5'd0: r = 26'd2949120;  5'd1: r = 26'd1740967;
        5'd2: r = 26'd919879;   5'd3: r = 26'd466945;
        5'd4: r = 26'd234379;   5'd5: r = 26'd117304;
        5'd6: r = 26'd58666;    5'd7: r = 26'd29335;
        5'd8: r = 26'd14668;    5'd9: r = 26'd7334;
        5'd10: r = 26'd3667;    5'd11: r = 26'd1833;
        5'd12: r = 26'd917;     5'd13: r = 26'd458;
        5'd14: r = 26'd229;     5'd15: r = 26'd115;
        5'd16: r = 26'd57;      5'd17: r = 26'd29;
        5'd18: r = 26'd14;      5'd19: r = 26'd7;
        5'd20: r = 26'd4;       5'd21: r = 26'd2;
        5'd22: r = 26'd1;       default: r = '0;
      endcase
      return r;
    end
  endfunction

  // sector angle in 1/128 degree
  function automatic logic signed [16:0] sec_ang(input logic [2:0] s);
    logic signed [16:0] r;
    begin
      case (s)
        3'd0: r = 17'sd11520; 3'd1: r = 17'sd19200; 3'd2: r = 17'sd26880;
        3'd3: r = 17'sd34560; 3'd4: r = 17'sd42240; 3'd5: r = 17'sd3840;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    begin
      if (v > 40'sd32767) r = 16'sh7fff;
      else if (v < -40'sd32768) r = -16'sd32768;
      else r = v[15:0];
      return r;
    end
  endfunction

endpackage

// ----- design/pad_to_lab_coordinate_transform_top.sv -----
// top level: front end, chain of cordic cells and result register
// One pad request is taken in every cycle (busy stays low); the result
// passes through the front end's two stages, one cell per cordic stage and
// the output register, and appears with result_valid high for one cycle.
// Results cannot be stalled by the receiver.
module pad_to_lab_coordinate_transform_top #(
  parameter int CORDIC_STAGES = ptl_pkg::CordicStagesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          sector,
  input  logic signed [15:0]  pad_local_x,
  input  logic signed [15:0]  pad_local_y,
  input  logic signed [16:0]  reference_azimuth,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data,
  output logic                result_valid,
  output logic                sector_enabled,
  output logic signed [15:0]  lab_x,
  output logic signed [15:0]  lab_y,
  output logic signed [15:0]  lab_z,
  output logic signed [16:0]  azimuth,
  output logic                azimuth_mismatch
);

  logic [5:0] sector_mask;
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      sector_mask <= cfg_data;
    end
  end

  ptl_pkg::ptl_cell_t chain [CORDIC_STAGES+1];

  ptl_front u_front (
    .clk, .rst,
    .req(start && !busy),
    .sector_mask, .sector, .pad_local_x, .pad_local_y, .reference_azimuth,
    .cell_out(chain[0])
  );

  // row of cordic cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ptl_cordic_cell #(.Index(i)) u_cell (
      .clk, .rst, .cell_in(chain[i]), .cell_out(chain[i+1])
    );
  end

  // azimuth rounding and mismatch
  ptl_pkg::ptl_cell_t last;
  logic signed [ptl_pkg::AW-1:0] phi_w;
  logic signed [16:0] az_next;
  logic signed [17:0] diff;
  always_comb begin
    last    = chain[CORDIC_STAGES];
    phi_w   = (last.ang + ptl_pkg::AW'(256)) >>> 9;
    az_next = (last.origin ? 17'sd0 : 17'(phi_w)) + ptl_pkg::sec_ang(last.sector);
    diff    = 18'(last.ref_az) - 18'(az_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= last.valid;
    end
    sector_enabled   <= last.enabled;
    lab_x            <= last.enabled ? last.lab_x : '0;
    lab_y            <= last.enabled ? last.lab_y : '0;
    lab_z            <= last.enabled ? last.lab_z : '0;
    azimuth          <= last.enabled ? az_next : '0;
    azimuth_mismatch <= last.enabled && (last.ref_az > 0) && (diff > 18'sd1);
  end

endmodule

// ----- design/ptl_cordic_cell.sv -----
// one vectoring cordic cell: a micro-rotation and a register
module ptl_cordic_cell #(
  parameter int Index = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptl_pkg::ptl_cell_t   cell_in,
  output ptl_pkg::ptl_cell_t   cell_out
);

  localparam logic [4:0] Idx = 5'(Index);
  localparam int Shift = Index;

  ptl_pkg::ptl_cell_t cell_next;
  logic signed [ptl_pkg::CW-1:0] dx;
  logic signed [ptl_pkg::CW-1:0] dy;

  // arithmetic shifts floor as required
  always_comb begin
    dx = cell_in.y >>> Shift;
    dy = cell_in.x >>> Shift;
    cell_next = cell_in;
    if (cell_in.y > 0) begin
      cell_next.x = cell_in.x + dx;
      cell_next.y = cell_in.y - dy;
      cell_next.ang = cell_in.ang + $signed(ptl_pkg::atan_q16(Idx));
    end else begin
      cell_next.x = cell_in.x - dx;
      cell_next.y = cell_in.y + dy;
      cell_next.ang = cell_in.ang - $signed(ptl_pkg::atan_q16(Idx));
    end
  end

  // cell register, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out <= '0;
    end else begin
      cell_out <= cell_next;
    end
  end

endmodule

// ----- design/ptl_front.sv -----
// front end: tilt, sector rotation and cordic pre-rotation
module ptl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req,
  input  logic [5:0]          sector_mask,
  input  logic [2:0]          sector,
  input  logic signed [15:0]  pad_local_x,
  input  logic signed [15:0]  pad_local_y,
  input  logic signed [16:0]  reference_azimuth,
  output ptl_pkg::ptl_cell_t  cell_out
);

  localparam int CW = ptl_pkg::CW;
  localparam int AW = ptl_pkg::AW;

  // stage 1 registers: products
  logic                valid1;
  logic                en1;
  logic [2:0]          sec1;
  logic signed [33:0]  xl1;      // py * cos20, 16 fraction bits
  logic signed [15:0]  px1;
  logic signed [31:0]  zp1;
  logic signed [16:0]  ref1;

  logic en0;
  assign en0 = (sector < 3'd6) && sector_mask[sector];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= req;
    end
    en1  <= en0;
    sec1 <= sector;
    xl1  <= 34'(pad_local_y * $signed({1'b0, ptl_pkg::Cos20Q16}));
    zp1  <= 32'(pad_local_y * $signed({1'b0, ptl_pkg::Sin20Q16}));
    px1  <= pad_local_x;
    ref1 <= reference_azimuth;
  end

  // sector rotation using cos/sin of 0, 1/2, sqrt3/2, 1
  logic signed [CW-1:0] xl;
  logic signed [CW-1:0] yl;
  logic signed [55:0] xs;   // xl * sqrt3/2 in Q32
  logic signed [55:0] ys;
  logic signed [55:0] xh;   // xl * 1/2 in Q32
  logic signed [55:0] yh;
  logic signed [55:0] xo;
  logic signed [55:0] yo;
  logic signed [55:0] lxw;
  logic signed [55:0] lyw;
  logic signed [55:0] rnd;
  logic signed [55:0] lzw;
  ptl_pkg::ptl_cell_t cell_next;

  always_comb begin
    xl  = CW'(xl1);
    yl  = CW'($signed({px1, 16'h0}));
    xs  = 56'(xl) * 56'sd56756;
    ys  = 56'(yl) * 56'sd56756;
    xh  = 56'(xl) <<< 15;
    yh  = 56'(yl) <<< 15;
    xo  = 56'(xl) <<< 16;
    yo  = 56'(yl) <<< 16;
    case (sec1)
      3'd0: begin lxw = -yo;      lyw = xo;       end
      3'd1: begin lxw = -xs - yh; lyw = xh - ys;  end
      3'd2: begin lxw = -xs + yh; lyw = -xh - ys; end
      3'd3: begin lxw = yo;       lyw = -xo;      end
      3'd4: begin lxw = xs + yh;  lyw = -xh + ys; end
      3'd5: begin lxw = xs - yh;  lyw = xh + ys;  end
      default: begin lxw = '0; lyw = '0; end
    endcase
    rnd = 56'sd1 <<< 31;
    lzw = (56'(zp1) + 56'sd32768) >>> 16;
    cell_next = '0;
    cell_next.valid   = valid1;
    cell_next.enabled = en1;
    cell_next.sector  = sec1;
    cell_next.ref_az  = ref1;
    cell_next.origin  = (xl == '0) && (yl == '0);
    cell_next.lab_x   = ptl_pkg::sat16(40'((lxw + rnd) >>> 32));
    cell_next.lab_y   = ptl_pkg::sat16(40'((lyw + rnd) >>> 32));
    cell_next.lab_z   = ptl_pkg::sat16(40'(lzw));
    // pre-rotation into the right half plane
    if (xl < 0) begin
      if (yl >= 0) begin
        cell_next.x = yl; cell_next.y = -xl;
        cell_next.ang = AW'(90 * 65536);
      end else begin
        cell_next.x = -yl; cell_next.y = xl;
        cell_next.ang = -AW'(90 * 65536);
      end
    end else begin
      cell_next.x = xl; cell_next.y = yl; cell_next.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out <= '0;
    end else begin
      cell_out <= cell_next;
    end
  end

endmodule

// ----- design/ptl_checker.sv -----
// port-level checker for the pad to lab transform, bound to the top level
module ptl_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic result_valid,
  input logic sector_enabled,
  input logic azimuth_mismatch,
  input logic signed [15:0] lab_x,
  input logic signed [16:0] azimuth
);

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !sector_enabled) |-> (lab_x == 0 && azimuth == 0 && !azimuth_mismatch))
    else $error("disabled sector result not zero");

  a_mismatch_enabled: assert property (@(posedge clk) disable iff (rst)
    azimuth_mismatch |-> sector_enabled)
    else $error("mismatch on disabled sector");

endmodule

bind pad_to_lab_coordinate_transform_top ptl_checker u_ptl_checker (
  .clk, .rst, .busy, .result_valid, .sector_enabled, .azimuth_mismatch,
  .lab_x, .azimuth
);

// ----- sim/testbench.sv -----
// self-checking testbench for the pad to lab coordinate transform
module testbench;

  localparam int Stages = ptl_pkg::CordicStagesDefault;
  localparam int Latency = Stages + 3;

  typedef struct packed {
    logic               enabled;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] lz;
    logic signed [16:0] az;
    logic               mismatch;
  } lab_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] sector = '0;
  logic signed [15:0] pad_local_x = '0;
  logic signed [15:0] pad_local_y = '0;
  logic signed [16:0] reference_azimuth = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = '0;
  logic result_valid;
  logic sector_enabled;
  logic signed [15:0] lab_x;
  logic signed [15:0] lab_y;
  logic signed [15:0] lab_z;
  logic signed [16:0] azimuth;
  logic azimuth_mismatch;

  logic [5:0] active_sectors = '0;
  lab_point_t expected_points[$];
  int error_count = 0;
  bit idle_enable = 1'b1;

  pad_to_lab_coordinate_transform_top #(.CORDIC_STAGES(Stages)) dut (.*);

  always #1 clk = ~clk;

  // floor of v / 2^s after adding half
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  // vectoring cordic, angle in 2^-16 degree
  function automatic longint vector_angle(input longint xi, input longint yi);
    longint x, y, t, ang, dx, dy;
    longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
      7, 4, 2, 1, 0};
    x = xi; y = yi; ang = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; ang = -90 * 65536;
      end
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += atan_tab[i];
      end else begin
        x -= dx; y += dy; ang -= atan_tab[i];
      end
    end
    return ang;
  endfunction

  // expected lab point for one pad
  function automatic lab_point_t transform_pad(input logic [2:0] s,
      input logic signed [15:0] px, input logic signed [15:0] py,
      input logic signed [16:0] ref_az);
    lab_point_t r;
    longint c, sn, sa, xl, yl, phi, az;
    longint cos_tab[6] = '{0, -56756, -56756, 0, 56756, 56756};
    longint sin_tab[6] = '{65536, 32768, -32768, -65536, -32768, 32768};
    longint ang_tab[6] = '{11520, 19200, 26880, 34560, 42240, 3840};
    r = '0;
    if (s > 5 || !active_sectors[s]) return r;
    c = cos_tab[s]; sn = sin_tab[s]; sa = ang_tab[s];
    xl = longint'(py) * 61583;
    yl = longint'(px) * 65536;
    r.enabled = 1'b1;
    r.lz = 16'(clamp16(round_half_up(longint'(py) * 22415, 16)));
    r.lx = 16'(clamp16(round_half_up(c * xl - sn * yl, 32)));
    r.ly = 16'(clamp16(round_half_up(sn * xl + c * yl, 32)));
    phi = (xl == 0 && yl == 0) ? 0 : round_half_up(vector_angle(xl, yl), 9);
    az = phi + sa;
    r.az = az[16:0];
    r.mismatch = (ref_az > 0) && (longint'(ref_az) - az > 1);
    return r;
  endfunction

  // random idle cycles on the sending side
  task automatic maybe_idle();
    while (idle_enable && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // send one pad request
  task automatic send_pad(input logic [2:0] s, input logic signed [15:0] px,
      input logic signed [15:0] py, input logic signed [16:0] ref_az);
    maybe_idle();
    start <= 1'b1;
    sector <= s;
    pad_local_x <= px;
    pad_local_y <= py;
    reference_azimuth <= ref_az;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_points.push_back(transform_pad(s, px, py, ref_az));
    @(negedge clk);
  endtask

  // wait for all results, then write the sector mask
  task automatic write_mask(input logic [5:0] m);
    start <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active_sectors = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // check each result against the oldest expectation
  always @(posedge clk) begin
    lab_point_t e;
    if (!rst && result_valid) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result az=%0d", $time, azimuth);
        error_count++;
      end else begin
        e = expected_points.pop_front();
        if (sector_enabled !== e.enabled) begin
          $display("%0t: enabled exp %0d got %0d", $time, e.enabled, sector_enabled);
          error_count++;
        end
        if (lab_x !== e.lx) begin
          $display("%0t: lab_x exp %0d got %0d", $time, e.lx, lab_x);
          error_count++;
        end
        if (lab_y !== e.ly) begin
          $display("%0t: lab_y exp %0d got %0d", $time, e.ly, lab_y);
          error_count++;
        end
        if (lab_z !== e.lz) begin
          $display("%0t: lab_z exp %0d got %0d", $time, e.lz, lab_z);
          error_count++;
        end
        if (azimuth !== e.az) begin
          $display("%0t: azimuth exp %0d got %0d", $time, e.az, azimuth);
          error_count++;
        end
        if (azimuth_mismatch !== e.mismatch) begin
          $display("%0t: mismatch exp %0d got %0d", $time, e.mismatch,
                   azimuth_mismatch);
          error_count++;
        end
      end
    end
  end

  function automatic logic signed [16:0] random_reference();
    case ($urandom_range(3))
      0: return '0;
      1: return 17'($signed($urandom_range(19200)) * -1);
      default: return 17'($urandom_range(65280));
    endcase
  endfunction

  function automatic logic signed [15:0] random_coord();
    case ($urandom_range(5))
      0: return 16'($urandom_range(8) - 4);
      1: return 16'sh7fff;
      2: return -16'sd32768;
      default: return 16'($urandom);
    endcase
  endfunction

  // extremes, origin, axes and disabled sectors
  task automatic test_directed();
    write_mask(6'h3f);
    send_pad(3'd0, 16'sd0, 16'sd0, 17'sd11520);
    send_pad(3'd1, 16'sd0, -16'sd100, 17'sd0);
    send_pad(3'd2, 16'sh7fff, 16'sh7fff, 17'sd65280);
    send_pad(3'd3, -16'sd32768, -16'sd32768, -17'sd19200);
    send_pad(3'd4, 16'sh7fff, -16'sd32768, 17'sd1);
    send_pad(3'd5, -16'sd32768, 16'sh7fff, 17'sd40000);
    send_pad(3'd0, 16'sd0, 16'sd500, 17'sd30000);
    send_pad(3'd1, 16'sd500, 16'sd0, 17'sd30000);
    send_pad(3'd2, -16'sd500, 16'sd0, 17'sd30000);
    send_pad(3'd6, 16'sd5, 16'sd5, 17'sd5);
    send_pad(3'd7, -16'sd5, 16'sd5, 17'sd5);
    write_mask(6'h00);
    for (int s = 0; s < 8; s++) send_pad(3'(s), 16'sd10, -16'sd10, 17'sd100);
    write_mask(6'h15);
    for (int s = 0; s < 6; s++) send_pad(3'(s), -16'sd1, 16'sd1, 17'sd2);
  endtask

  // random pads over several masks
  task automatic test_random();
    logic [5:0] masks[4] = '{6'h3f, 6'h2a, 6'h3f, 6'h3f};
    for (int p = 0; p < 4; p++) begin
      write_mask(p == 1 ? masks[p] : 6'($urandom_range(1) ? 6'h3f : $urandom));
      idle_enable = (p != 2);
      repeat (500) send_pad(3'($urandom_range(99) < 5 ? 6 + $urandom_range(1)
          : $urandom_range(5)), random_coord(), random_coord(), random_reference());
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    start <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
